// ===== rtl/dfamc_pkg.sv =====
// ----------------------------------------------------------------------------
// dfamc_pkg
// Shared types and constants of the dfa run and minimality check unit.
// ----------------------------------------------------------------------------
package dfamc_pkg;

  // largest number of states, sets mask widths and store depths
  localparam int unsigned MaxStates  = 16;
  localparam int unsigned StateW     = 4;
  localparam int unsigned CountW     = 5;
  localparam int unsigned TableDepth = 2 * MaxStates;
  localparam int unsigned WorkDepth  = 2 * MaxStates;

  // configuration register indexes
  localparam logic [1:0] CfgFinalStates = 2'd0;
  localparam logic [1:0] CfgStateCount  = 2'd1;

  // result kinds
  localparam logic KindWord  = 1'b0;
  localparam logic KindCheck = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_END   = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [3:0]       state_index;
    logic             symbol;
    logic [3:0]       next_state;
  } in_item_t;

  typedef struct packed {
    logic result_kind;
    logic verdict;
  } out_item_t;

  // refinement sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_INIT2,
    S_POP,
    S_POP_WAIT,
    S_X,
    S_K,
    S_K_WAIT,
    S_WR1,
    S_WR2,
    S_PS,
    S_P_WAIT,
    S_PADD,
    S_F_RD,
    S_F_WAIT,
    S_DONE
  } seq_e;

endpackage

// ===== rtl/dfa_run_and_minimality_check_unit.sv =====
// ----------------------------------------------------------------------------
// dfa_run_and_minimality_check_unit
// Table-driven binary DFA with word acceptance and a partition-refinement
// minimality check.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i / in_stall_o, results leave on
// out_valid_o / out_stall_i; an item moves at an edge with valid high and
// stall low. Registers final_states (index 0) and state_count (index 1) are
// written over the cfg channel, which is always ready.
// Table writes, symbol steps and end-of-word items can follow back to back
// while no result is held; a step reads the table memory and the next step
// uses the read data directly from the table read port.
// An end-of-word verdict appears in the output register in the cycle after the
// item. A check item runs a sequencer over the work memory (blocks and
// pending splitters) and the table memory, one access a cycle, until the
// verdict is registered; no item is taken meanwhile.
// Reset clears the current state, the block and pending counts and the output valid flag;
// table and work memory are not cleared. While the receiver stalls with a
// result held, the input is stalled too.
// ----------------------------------------------------------------------------
module dfa_run_and_minimality_check_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dfamc_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dfamc_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import dfamc_pkg::*;

  // configuration
  logic [15:0]       final_q;
  logic [CountW-1:0] count_q;

  // word run
  logic [StateW-1:0] cur_q, cur_d, cur_eff;
  logic              step_q, step_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      out_free;

  // sequencer
  seq_e              st_q, st_d;
  logic [CountW-1:0] bc_q, bc_d, pc_q, pc_d;
  logic [CountW-1:0] j_q, j_d, k_q, k_d, p_q, p_d, lim_q, lim_d;
  logic [StateW-1:0] jd_q, jd_d;
  logic              xv_q, xv_d;
  logic              sym_q, sym_d;
  logic              found_q, found_d;
  logic              ok_q, ok_d;
  logic [15:0]       a_q, a_d, x_q, x_d, y_q, y_d, y1_q, y1_d, y2_q, y2_d;

  // memory ports
  logic              t_we, t_re, w_we, w_re;
  logic [4:0]        t_waddr, t_raddr, w_waddr, w_raddr;
  logic [StateW-1:0] t_wdata, t_rdata;
  logic [15:0]       w_wdata, w_rdata;

  // derived check values
  logic [CountW-1:0] n_use;
  logic [15:0]       all_m, fin_m, rest_m, ny1, ny2;
  logic              accept;

  function automatic logic [CountW-1:0] pop16(input logic [15:0] v);
    logic [CountW-1:0] c;
    c = '0;
    for (int i = 0; i < 16; i++) begin
      c = c + CountW'(v[i]);
    end
    return c;
  endfunction

  dfamc_ram #(.WIDTH(StateW), .DEPTH(TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  dfamc_ram #(.WIDTH(16), .DEPTH(WorkDepth)) u_work (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (st_q != S_IDLE) || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign cur_eff     = step_q ? t_rdata : cur_q;

  // state count saturated and masks
  assign n_use  = (count_q > CountW'(MaxStates)) ? CountW'(MaxStates) : count_q;
  assign all_m  = (n_use >= CountW'(16)) ? 16'hFFFF : ((16'd1 << n_use) - 16'd1);
  assign fin_m  = final_q & all_m;
  assign rest_m = ~final_q & all_m;
  assign ny1    = w_rdata & x_q;
  assign ny2    = w_rdata & ~x_q & all_m;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_q <= '0;
      count_q <= CountW'(MaxStates);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgFinalStates) begin
        final_q <= cfg_data_i;
      end else if (cfg_index_i == CfgStateCount) begin
        count_q <= cfg_data_i[CountW-1:0];
      end
    end
  end

  // next state, memory access and outputs
  always_comb begin
    st_d        = st_q;
    cur_d       = cur_eff;
    step_d      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    bc_d        = bc_q;
    pc_d        = pc_q;
    j_d         = j_q;
    jd_d        = jd_q;
    xv_d        = 1'b0;
    k_d         = k_q;
    p_d         = p_q;
    lim_d       = lim_q;
    sym_d       = sym_q;
    found_d     = found_q;
    ok_d        = ok_q;
    a_d         = a_q;
    x_d         = x_q;
    y_d         = y_q;
    y1_d        = y1_q;
    y2_d        = y2_q;
    t_we        = 1'b0;
    t_waddr     = {in_item_i.state_index, in_item_i.symbol};
    t_wdata     = in_item_i.next_state;
    t_re        = 1'b0;
    t_raddr     = {cur_eff, in_item_i.symbol};
    w_we        = 1'b0;
    w_waddr     = '0;
    w_wdata     = '0;
    w_re        = 1'b0;
    w_raddr     = '0;

    // predecessor bits collected in the cycle after each table read
    if (xv_q && a_q[t_rdata]) begin
      x_d[jd_q] = 1'b1;
    end

    case (st_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.op)
            OP_WRITE: t_we = 1'b1;
            OP_STEP: begin
              t_re   = 1'b1;
              step_d = 1'b1;
            end
            OP_END: begin
              out_valid_d       = 1'b1;
              out_d.result_kind = KindWord;
              out_d.verdict     = final_q[cur_eff];
              cur_d             = '0;
            end
            default: st_d = S_INIT0;
          endcase
        end
      end
      S_INIT0: begin
        bc_d = '0;
        pc_d = '0;
        if (fin_m != '0) begin
          w_we    = 1'b1;
          w_waddr = 5'd0;
          w_wdata = fin_m;
          bc_d    = CountW'(1);
        end
        st_d = S_INIT1;
      end
      S_INIT1: begin
        if (rest_m != '0) begin
          w_we    = 1'b1;
          w_waddr = {1'b0, bc_q[3:0]};
          w_wdata = rest_m;
          bc_d    = bc_q + CountW'(1);
        end
        st_d = S_INIT2;
      end
      S_INIT2: begin
        if (fin_m != '0) begin
          w_we    = 1'b1;
          w_waddr = 5'b10000;
          w_wdata = fin_m;
          pc_d    = CountW'(1);
        end
        st_d = S_POP;
      end
      S_POP: begin
        if (pc_q != '0) begin
          w_re    = 1'b1;
          w_raddr = {1'b1, 4'(pc_q - CountW'(1))};
          pc_d    = pc_q - CountW'(1);
          st_d    = S_POP_WAIT;
        end else begin
          k_d  = '0;
          ok_d = 1'b1;
          st_d = S_F_RD;
        end
      end
      S_POP_WAIT: begin
        a_d   = w_rdata;
        sym_d = 1'b0;
        j_d   = '0;
        x_d   = '0;
        st_d  = S_X;
      end
      S_X: begin
        if (j_q < n_use) begin
          t_re    = 1'b1;
          t_raddr = {j_q[3:0], sym_q};
          jd_d    = j_q[3:0];
          xv_d    = 1'b1;
          j_d     = j_q + CountW'(1);
        end else if (!xv_q) begin
          lim_d = bc_q;
          k_d   = '0;
          st_d  = S_K;
        end
      end
      S_K: begin
        if (k_q < lim_q) begin
          w_re    = 1'b1;
          w_raddr = {1'b0, k_q[3:0]};
          st_d    = S_K_WAIT;
        end else if (!sym_q) begin
          sym_d = 1'b1;
          j_d   = '0;
          x_d   = '0;
          st_d  = S_X;
        end else begin
          st_d = S_POP;
        end
      end
      S_K_WAIT: begin
        y_d  = w_rdata;
        y1_d = ny1;
        y2_d = ny2;
        if ((ny1 != '0) && (ny2 != '0) && (bc_q < CountW'(MaxStates))) begin
          st_d = S_WR1;
        end else begin
          k_d  = k_q + CountW'(1);
          st_d = S_K;
        end
      end
      S_WR1: begin
        w_we    = 1'b1;
        w_waddr = {1'b0, k_q[3:0]};
        w_wdata = y1_q;
        st_d    = S_WR2;
      end
      S_WR2: begin
        w_we    = 1'b1;
        w_waddr = {1'b0, bc_q[3:0]};
        w_wdata = y2_q;
        bc_d    = bc_q + CountW'(1);
        p_d     = '0;
        found_d = 1'b0;
        st_d    = S_PS;
      end
      S_PS: begin
        if ((p_q < pc_q) && !found_q) begin
          w_re    = 1'b1;
          w_raddr = {1'b1, p_q[3:0]};
          st_d    = S_P_WAIT;
        end else begin
          st_d = S_PADD;
        end
      end
      S_P_WAIT: begin
        if (w_rdata == y_q) begin
          w_we    = 1'b1;
          w_waddr = {1'b1, p_q[3:0]};
          w_wdata = y1_q;
          found_d = 1'b1;
        end
        p_d  = p_q + CountW'(1);
        st_d = S_PS;
      end
      S_PADD: begin
        if (pc_q < CountW'(MaxStates)) begin
          w_we    = 1'b1;
          w_waddr = {1'b1, pc_q[3:0]};
          if (found_q) begin
            w_wdata = y2_q;
          end else begin
            w_wdata = (pop16(y1_q) < pop16(y2_q)) ? y1_q : y2_q;
          end
          pc_d = pc_q + CountW'(1);
        end
        k_d  = k_q + CountW'(1);
        st_d = S_K;
      end
      S_F_RD: begin
        if (k_q < bc_q) begin
          w_re    = 1'b1;
          w_raddr = {1'b0, k_q[3:0]};
          st_d    = S_F_WAIT;
        end else begin
          st_d = S_DONE;
        end
      end
      S_F_WAIT: begin
        if ((w_rdata & (w_rdata - 16'd1)) != '0) begin
          ok_d = 1'b0;
        end
        k_d  = k_q + CountW'(1);
        st_d = S_F_RD;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = KindCheck;
          out_d.verdict     = ok_q;
          st_d              = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cur_q       <= '0;
      step_q      <= 1'b0;
      out_valid_q <= 1'b0;
      bc_q        <= '0;
      pc_q        <= '0;
      xv_q        <= 1'b0;
    end else begin
      st_q        <= st_d;
      cur_q       <= cur_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      bc_q        <= bc_d;
      pc_q        <= pc_d;
      xv_q        <= xv_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    j_q     <= j_d;
    jd_q    <= jd_d;
    k_q     <= k_d;
    p_q     <= p_d;
    lim_q   <= lim_d;
    sym_q   <= sym_d;
    found_q <= found_d;
    ok_q    <= ok_d;
    a_q     <= a_d;
    x_q     <= x_d;
    y_q     <= y_d;
    y1_q    <= y1_d;
    y2_q    <= y2_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> in_stall_o)
    else $error("item accepted while refinement runs");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bc_q <= CountW'(MaxStates)) && (pc_q <= CountW'(MaxStates)))
    else $error("block or pending count overflow");

  a_step_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q |-> ($past(st_q) == S_IDLE))
    else $error("table step pending outside idle");

  a_check_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE && out_free) |=> (out_valid_o && out_item_o.result_kind == KindCheck))
    else $error("check verdict not presented");

endmodule

// ===== rtl/dfamc_ram.sv =====
// ----------------------------------------------------------------------------
// dfamc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfamc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dfa run and minimality check unit. A table of
// directed items is followed by random words, table rewrites and minimality
// checks over several register settings. Every verdict is compared with an
// in-bench DFA and partition-refinement predictor, or with a verdict read
// off by hand for typed rows, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import dfamc_pkg::*;

  // directed row: the item plus an optional verdict read off by hand
  typedef struct {
    op_e        op;
    logic [3:0] state_index;
    logic       symbol;
    logic [3:0] next_state;
    bit         typed;
    logic       verdict;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor copy of the dfa and its registers
  logic [3:0]  dfa_table [32];
  logic [3:0]  dfa_state;
  logic [15:0] accept_mask;
  logic [4:0]  num_states;

  out_item_t   verdict_q[$];
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  bit          long_hold_req = 1'b0;

  dir_row_t dir_rows[$];

  dfa_run_and_minimality_check_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // hopcroft refinement over the predictor table, 1 when every block is a singleton
  function automatic logic minimal_verdict();
    int unsigned n, nblk, npend, lim, k, p, j, s;
    logic [15:0] all, fin, rest, spl, pred, y, y1, y2;
    logic [15:0] blk [16];
    logic [15:0] pend [16];
    bit found;
    n = (num_states > 16) ? 16 : num_states;
    all = 16'((17'd1 << n) - 17'd1);
    fin = accept_mask & all;
    rest = ~fin & all;
    nblk = 0;
    npend = 0;
    if (fin != 0) begin
      blk[nblk] = fin;
      nblk++;
    end
    if (rest != 0) begin
      blk[nblk] = rest;
      nblk++;
    end
    if (fin != 0) begin
      pend[npend] = fin;
      npend++;
    end
    while (npend > 0) begin
      npend--;
      spl = pend[npend];
      for (s = 0; s < 2; s++) begin
        // predecessors of the splitter under this symbol
        pred = '0;
        for (j = 0; j < n; j++)
          if (spl[dfa_table[j * 2 + s]]) pred[j] = 1'b1;
        lim = nblk;
        for (k = 0; k < lim; k++) begin
          y = blk[k];
          y1 = y & pred;
          y2 = y & ~pred & all;
          if (y1 == 0 || y2 == 0 || nblk >= 16) continue;
          blk[k] = y1;
          blk[nblk] = y2;
          nblk++;
          found = 1'b0;
          for (p = 0; p < npend; p++) begin
            if (pend[p] == y) begin
              pend[p] = y1;
              found = 1'b1;
              break;
            end
          end
          if (npend >= 16) continue;
          if (found) pend[npend] = y2;
          else pend[npend] = ($countones(y1) < $countones(y2)) ? y1 : y2;
          npend++;
        end
      end
    end
    for (k = 0; k < nblk; k++)
      if ($countones(blk[k]) > 1) return 1'b0;
    return 1'b1;
  endfunction

  // advance the predictor by one accepted item, returns 1 when a verdict is due
  function automatic bit predict_item(in_item_t it, output out_item_t res);
    res = '0;
    case (it.op)
      OP_WRITE: begin
        dfa_table[{it.state_index, it.symbol}] = it.next_state;
        return 1'b0;
      end
      OP_STEP: begin
        dfa_state = dfa_table[{dfa_state, it.symbol}];
        return 1'b0;
      end
      OP_END: begin
        res.result_kind = KindWord;
        res.verdict = accept_mask[dfa_state];
        dfa_state = '0;
        return 1'b1;
      end
      default: begin
        res.result_kind = KindCheck;
        res.verdict = minimal_verdict();
        return 1'b1;
      end
    endcase
  endfunction

  // offer one item in bursts with random gaps; typed verdict overrides the predictor
  task automatic send_item(in_item_t it, bit typed = 1'b0, logic verdict = 1'b0);
    out_item_t res;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (!no_gaps && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    forever begin
      @(negedge clk_i);
      if (!in_stall) break;
    end
    @(posedge clk_i);
    if (predict_item(it, res)) begin
      if (typed) res.verdict = verdict;
      verdict_q = {verdict_q, res};
    end
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(negedge clk_i);
      if (cfg_ready) break;
    end
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CfgFinalStates) accept_mask = data;
    else num_states = data[4:0];
    @(posedge clk_i);
  endtask

  function automatic in_item_t rand_item(op_e op);
    in_item_t it;
    it.op = op;
    it.state_index = 4'($urandom_range(0, 15));
    it.symbol = 1'($urandom_range(0, 1));
    it.next_state = 4'($urandom_range(0, 15));
    return it;
  endfunction

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned mode, len, pct;
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      mode = $urandom_range(0, 9);
      len = $urandom_range(5, 60);
      pct = (mode < 2) ? 0 : (mode < 8) ? 30 : 70;
      repeat (len) begin
        out_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
      end
    end
  end

  // compare each result leaving the block with the oldest expectation
  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d verdict %0d",
                 $time, out_item.result_kind, out_item.verdict);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_item.result_kind !== want.result_kind) begin
          $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                   $time, want.result_kind, out_item.result_kind);
          errors++;
        end
        if (out_item.verdict !== want.verdict) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d",
                   $time, want.verdict, out_item.verdict);
          errors++;
        end
      end
    end
  end

  initial begin
    in_item_t it;
    int unsigned ph, cnt, len, r, i;
    logic [15:0] mask_pick;
    logic [4:0] count_pick;
    dfa_state = '0;
    accept_mask = '0;
    num_states = 5'd16;
    foreach (dfa_table[i]) dfa_table[i] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: empty word, a full table fill and a check, then extremes
    dir_rows.insert(dir_rows.size(), '{OP_END,   4'd0,  1'b0, 4'd0,  1'b1, 1'b0});
    for (i = 0; i < 32; i++)
      dir_rows.insert(dir_rows.size(), '{OP_WRITE, 4'(i / 2), 1'(i % 2),
                                         4'((i / 2 + i % 2 + 1) % 16), 1'b0, 1'b0});
    dir_rows.insert(dir_rows.size(), '{OP_CHECK, 4'd0,  1'b0, 4'd0,  1'b1, 1'b0});
    dir_rows.insert(dir_rows.size(), '{OP_WRITE, 4'd15, 1'b1, 4'd15, 1'b0, 1'b0});
    dir_rows.insert(dir_rows.size(), '{OP_WRITE, 4'd0,  1'b0, 4'd0,  1'b0, 1'b0});
    dir_rows.insert(dir_rows.size(), '{OP_STEP,  4'd15, 1'b0, 4'd15, 1'b0, 1'b0});
    dir_rows.insert(dir_rows.size(), '{OP_STEP,  4'd0,  1'b1, 4'd0,  1'b0, 1'b0});
    dir_rows.insert(dir_rows.size(), '{OP_STEP,  4'd0,  1'b1, 4'd0,  1'b0, 1'b0});
    dir_rows.insert(dir_rows.size(), '{OP_END,   4'd0,  1'b0, 4'd0,  1'b0, 1'b0});
    foreach (dir_rows[i])
      send_item('{dir_rows[i].op, dir_rows[i].state_index, dir_rows[i].symbol,
                  dir_rows[i].next_state}, dir_rows[i].typed, dir_rows[i].verdict);

    // all states accepting, then extreme and odd state counts
    drain_verdicts();
    write_reg(CfgFinalStates, 16'hFFFF);
    send_item(rand_item(OP_END), 1'b1, 1'b1);
    send_item(rand_item(OP_CHECK));
    for (i = 0; i < 4; i++) begin
      drain_verdicts();
      write_reg(CfgStateCount, (i == 0) ? 16'd0 : (i == 1) ? 16'd1 :
                               (i == 2) ? 16'd31 : 16'hFFE2);
      write_reg(CfgFinalStates, (i < 2) ? 16'h5A5A : 16'h0001);
      send_item(rand_item(OP_CHECK));
      send_item(rand_item(OP_STEP));
      send_item(rand_item(OP_END));
    end

    // random phases over varied settings
    for (ph = 0; ph < 10; ph++) begin
      drain_verdicts();
      r = $urandom_range(0, 5);
      mask_pick = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
      r = $urandom_range(0, 7);
      count_pick = (r == 0) ? 5'd2 : (r == 1) ? 5'd16 : (r == 2) ? 5'($urandom_range(17, 31)) :
                   (r == 3) ? 5'($urandom_range(0, 1)) : 5'($urandom_range(2, 6));
      if (ph == 0) count_pick = 5'd2;
      if (ph == 1) count_pick = 5'd16;
      write_reg(CfgStateCount, {11'($urandom()), count_pick});
      write_reg(CfgFinalStates, mask_pick);
      if (ph == 2) begin
        no_gaps = 1'b1;
        long_hold_req = 1'b1;
      end
      cnt = 0;
      while (cnt < 100) begin
        if (ph == 2 && cnt == 60) no_gaps = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 12) begin
          send_item(rand_item(OP_WRITE));
          cnt++;
        end else if (r < 16) begin
          send_item(rand_item(OP_CHECK));
          cnt++;
        end else if (r < 18) begin
          send_item(rand_item(OP_END));
          cnt++;
        end else begin
          // a word: some steps then its end
          len = $urandom_range(0, 10);
          repeat (len) send_item(rand_item(OP_STEP));
          send_item(rand_item(OP_END));
          cnt += len + 1;
        end
        if ($urandom_range(0, 99) == 0) drain_verdicts();
      end
    end

    drain_verdicts();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
